// ===== sv/skrs_pkg.sv =====
// ----------------------------------------------------------------------------
// skrs_pkg
// Shared types and constants for the scalar kalman rssi smoother.
// ----------------------------------------------------------------------------
package skrs_pkg;

  localparam int VAR_W     = 32;  // variance width, unsigned q16.16
  localparam int CFG_W     = 32;  // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_W    = 16;  // gain, q0.16
  localparam int SUM_W     = VAR_W + 1;
  localparam int REM_W     = VAR_W + 2;
  localparam int DIV_CNT_W = 4;   // counts the fraction bits of the gain

  localparam logic [CFG_IDX_W-1:0] REG_START_EST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [VAR_W-1:0] START_VAR_RST  = 32'd65536;
  localparam logic [VAR_W-1:0] MEAS_NOISE_RST = 32'd262144;
  localparam int               START_EST_RST  = -15360;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MULE = 7'b0001000,
    ST_MULP = 7'b0010000,
    ST_UPDP = 7'b0100000,
    ST_DONE = 7'b1000000
  } skrs_state_t;

endpackage

// ===== sv/scalar_kalman_rssi_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_rssi_smoother_unit
// Scalar kalman filter over bursts of rssi samples, one shared divider and
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one rssi sample per transaction (signed q8.8 in in_tdata),
//           in_tlast marks the last sample of a burst.
//   out_* : one transaction per burst, the final estimate (signed q8.8,
//           rounded and saturated) and the final variance (unsigned q16.16).
//   cfg_* : plain register writes (start estimate, start variance, noise R),
//           to be done while the block is idle.
// Timing:
//   after acceptance a sample passes a setup step (ST_SUM), the restoring divider
//   that forms the 16-bit gain (one quotient bit a cycle), the estimate and
//   variance products on the shared multiplier and the estimate and variance
//   updates before in_tready is back. When P + R is zero the divider is skipped.
//   A last sample's result is loaded from ST_DONE once the result slot is free.
// Reset and stalls:
//   reset loads the default registers and the start state, out_tvalid low.
//   a waiting result does not block the next sample; only when a new result
//   is ready while the old one is still not taken does the block hold.
// ----------------------------------------------------------------------------
module scalar_kalman_rssi_smoother_unit
  import skrs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // configuration
  input  logic                                        cfg_we,
  input  logic [CFG_IDX_W-1:0]                        cfg_addr,
  input  logic [CFG_W-1:0]                            cfg_wdata,
  // samples
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            in_tdata,  // rssi_sample
  input  logic                                        in_tlast,  // last_sample
  // results
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // filtered_rssi, final_variance
  output logic [((SAMPLE_BITS+VAR_W+7)/8)*8-1:0]      out_tdata
);

  localparam int S   = SAMPLE_BITS;
  localparam int E   = SAMPLE_BITS + 8;                 // estimate, q.16
  localparam int MW  = (E + 1 > SUM_W) ? E + 1 : SUM_W; // multiplier a side
  localparam int MBW = GAIN_W + 2;                      // multiplier b side
  localparam int PW  = MW + MBW;

  localparam logic signed [S-1:0]  EST_RST = S'(START_EST_RST);
  localparam logic signed [PW-1:0] EST_MAX = PW'((64'sd1 <<< (E - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] EST_MIN = -EST_MAX - PW'(1);
  localparam logic signed [S-1:0]  Q_MAX   = S'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [S-1:0]  Q_MIN   = -Q_MAX - S'(1);

  skrs_state_t state_r, state_nxt;

  logic signed [S-1:0]      start_est_r;
  logic [VAR_W-1:0]         start_var_r, noise_r;
  logic signed [E-1:0]      est_r, est_nxt;
  logic [VAR_W-1:0]         var_r, var_nxt;
  logic signed [S-1:0]      smp_r, smp_nxt;
  logic                     last_r, last_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [GAIN_W-1:0]        quo_r, quo_nxt;
  logic                     sat_r, sat_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [S-1:0]      out_est_r, out_est_nxt;
  logic [VAR_W-1:0]         out_var_r, out_var_nxt;

  logic [GAIN_W-1:0]        gain;
  logic signed [E:0]        diff;
  logic signed [MW-1:0]     mul_a;
  logic signed [MBW-1:0]    mul_b;
  logic signed [PW-1:0]     mul_p;
  logic [SUM_W-1:0]         sum_c;
  logic [REM_W-1:0]         rem_sh;
  logic signed [PW-1:0]     delta, est_sum;
  logic [PW-1:0]            var_rnd;
  logic signed [E:0]        est_rnd;
  logic signed [S:0]        q_full;
  logic signed [S-1:0]      q_sat;
  logic                     out_free;

  assign gain  = sat_r ? {GAIN_W{1'b1}} : quo_r;
  assign diff  = $signed({smp_r[S-1], smp_r, 8'b0}) - $signed({est_r[E-1], est_r});
  assign sum_c = {1'b0, var_r} + {1'b0, noise_r};
  assign rem_sh = {rem_r[REM_W-2:0], 1'b0};

  // shared multiplier, estimate step then variance step
  always_comb begin
    if (state_r == ST_MULE) begin
      mul_a = MW'(diff);
      mul_b = $signed({2'b00, gain});
    end else begin
      mul_a = $signed(MW'({1'b0, var_r}));
      mul_b = $signed(MBW'({1'b1, {GAIN_W{1'b0}}} - {1'b0, gain}));
    end
  end
  assign mul_p = mul_a * mul_b;

  // estimate += round(diff * gain), clamped to the estimate width
  assign delta   = (prod_r + PW'(32768)) >>> 16;
  assign est_sum = PW'(est_r) + delta;
  assign var_rnd = PW'(prod_r) + PW'(32768);

  // round q8.16 to q8.8 and saturate
  assign est_rnd = (E+1)'(est_r) + (E+1)'(128);
  assign q_full  = est_rnd[E:8];
  assign q_sat   = (q_full[S] != q_full[S-1]) ? (q_full[S] ? Q_MIN : Q_MAX)
                                              : q_full[S-1:0];

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    smp_nxt       = smp_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_est_nxt   = out_est_r;
    out_var_nxt   = out_var_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          smp_nxt   = $signed(in_tdata[S-1:0]);
          last_nxt  = in_tlast;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_c;
        quo_nxt = '0;
        cnt_nxt = '1;
        // p <= p + r, so the integer part of the gain is one only when r is zero
        if (sum_c == '0) begin
          sat_nxt   = 1'b0;
          state_nxt = ST_MULE;
        end else if ({1'b0, var_r} >= sum_c) begin
          sat_nxt   = 1'b1;
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          sat_nxt   = 1'b0;
          rem_nxt   = REM_W'(var_r);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sh >= REM_W'(sum_r)) begin
          rem_nxt = rem_sh - REM_W'(sum_r);
          quo_nxt = {quo_r[GAIN_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[GAIN_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_MULE;
        end
      end
      ST_MULE: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MULP;
      end
      ST_MULP: begin
        prod_nxt = mul_p;
        if (est_sum > EST_MAX) begin
          est_nxt = EST_MAX[E-1:0];
        end else if (est_sum < EST_MIN) begin
          est_nxt = EST_MIN[E-1:0];
        end else begin
          est_nxt = est_sum[E-1:0];
        end
        state_nxt = ST_UPDP;
      end
      ST_UPDP: begin
        var_nxt   = var_rnd[16 +: VAR_W];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = q_sat;
          out_var_nxt   = var_r;
          est_nxt       = {start_est_r, 8'b0};
          var_nxt       = start_var_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      start_est_r <= EST_RST;
      start_var_r <= START_VAR_RST;
      noise_r     <= MEAS_NOISE_RST;
      est_r       <= {EST_RST, 8'b0};
      var_r       <= START_VAR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_EST:  start_est_r <= $signed(cfg_wdata[S-1:0]);
          REG_START_VAR:  start_var_r <= cfg_wdata[VAR_W-1:0];
          REG_MEAS_NOISE: noise_r     <= cfg_wdata[VAR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_r     <= smp_nxt;
    last_r    <= last_nxt;
    sum_r     <= sum_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    sat_r     <= sat_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    out_est_r <= out_est_nxt;
    out_var_r <= out_var_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[S-1:0]     = out_est_r;
    out_tdata[S +: VAR_W] = out_var_r;
  end

endmodule

// ===== sv/skrs_checker.sv =====
// ----------------------------------------------------------------------------
// skrs_checker
// Port-level checks for the scalar kalman rssi smoother.
// ----------------------------------------------------------------------------
module skrs_checker
  import skrs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((SAMPLE_BITS+VAR_W+7)/8)*8-1:0] out_tdata
);

  // result channel is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // one sample at a time: in_tready is low while an accepted sample is in progress
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready)
    else $error("new sample taken while one is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind scalar_kalman_rssi_smoother_unit skrs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_skrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
